>>> rtl/core/irn_pkg.sv
// ----------------------------------------------------------------------------
// irn_pkg: shared definitions for the nearest-neighbor image rotator
// Field widths, register map codes, reset values and the operation bundle
// passed from the coordinate mapper to the frame store.
// ----------------------------------------------------------------------------
package irn_pkg;

  // Default frame store edge length in pixels.
  localparam int unsigned MAX_DIM_DEF = 64;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned DIM_REG_W = 7;
  localparam int unsigned FRAC_BITS = 14;

  // Stream packing: pix_x, pix_y, pix_in, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 48;

  // Configuration port.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [1:0] {
    REG_COS    = 2'd0,
    REG_SIN    = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } irn_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } irn_cmd_e;

  localparam logic signed [COEF_W-1:0] COS_RST    = 16'sd16384;
  localparam logic signed [COEF_W-1:0] SIN_RST    = 16'sd0;
  localparam logic [DIM_REG_W-1:0]     WIDTH_RST  = 7'd64;
  localparam logic [DIM_REG_W-1:0]     HEIGHT_RST = 7'd64;

  // Store operation for one request: wr stores a pixel, rd fetches an
  // in-image source pixel.
  typedef struct packed {
    logic wr;
    logic rd;
  } irn_op_t;

endpackage

>>> rtl/core/image_rotate_nearest.sv
// ----------------------------------------------------------------------------
// image_rotate_nearest: nearest-neighbor image rotation about the center
// Frame store plus inverse-mapping pipeline for RGBA images up to MAX_DIM
// square, rotated with a Q2.14 cosine/sine pair.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and returns exactly one result
// per request, in request order. A request with tuser low writes pix_in into
// the frame store at (pix_x, pix_y); its result carries pixel 0 and a clear
// inside flag. A request with tuser high names a destination pixel; the block
// centers it, rotates it back with the cosine and sine registers, rounds to
// the nearest source pixel (halves away from zero) and returns that stored
// pixel with the inside flag set, or pixel 0 with the flag clear when either
// the destination or the source lies outside the configured image. Three
// mapping stages (centering, the four coefficient products, the sums) feed a
// rounding and bounds stage, and the frame store, a single-port memory doing
// one access per request, registers the pixel into the output stage. Writes
// pass through the same stages, so a read always sees every earlier write.
// The output register lets the pipeline keep filling while a result waits;
// a stalled output stops the stages only once they are full. The frame store
// holds no reset value: read only pixels that have been written. Program the
// registers while no request is in flight.
// ----------------------------------------------------------------------------
module image_rotate_nearest #(
  parameter int unsigned MAX_DIM = irn_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] pix_x, [11:6] pix_y, [43:12] pix_in, [47:44] zero.
  input  logic [irn_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [0] cmd: 0 writes a source pixel, 1 reads a rotated pixel.
  input  logic                          s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] pix_out.
  output logic [irn_pkg::PIX_W-1:0]     m_axis_tdata,
  // [0] inside_res.
  output logic                          m_axis_tuser,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irn_pkg::APB_AW-1:0]    paddr,
  input  logic [irn_pkg::APB_DW-1:0]    pwdata,
  output logic [irn_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned CWI   = irn_pkg::COORD_W;

  logic signed [irn_pkg::COEF_W-1:0] rot_cos, rot_sin;
  logic [DIM_W-1:0]                  dim_w, dim_h;

  irn_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .rot_cos_o (rot_cos),
    .rot_sin_o (rot_sin),
    .dim_w_o   (dim_w),
    .dim_h_o   (dim_h)
  );

  // Request fields.
  irn_pkg::irn_cmd_e          req_cmd;
  logic [CWI-1:0]             req_x, req_y;
  logic [irn_pkg::PIX_W-1:0]  req_pix;

  assign req_cmd = irn_pkg::irn_cmd_e'(s_axis_tuser);
  assign req_x   = s_axis_tdata[CWI-1:0];
  assign req_y   = s_axis_tdata[2*CWI-1:CWI];
  assign req_pix = s_axis_tdata[2*CWI+irn_pkg::PIX_W-1:2*CWI];

  // Mapper to store handoff.
  logic                      st_valid, st_ready;
  irn_pkg::irn_op_t          st_op;
  logic [2*AW-1:0]           st_addr;
  logic [irn_pkg::PIX_W-1:0] st_pix;

  irn_map #(.MAX_DIM(MAX_DIM)) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .cmd_i      (req_cmd),
    .x_i        (req_x),
    .y_i        (req_y),
    .pix_i      (req_pix),
    .rot_cos_i  (rot_cos),
    .rot_sin_i  (rot_sin),
    .dim_w_i    (dim_w),
    .dim_h_i    (dim_h),
    .st_ready_i (st_ready),
    .st_valid_o (st_valid),
    .st_op_o    (st_op),
    .st_addr_o  (st_addr),
    .st_pix_o   (st_pix)
  );

  irn_store #(.MAX_DIM(MAX_DIM)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (st_valid),
    .ready_o    (st_ready),
    .op_i       (st_op),
    .addr_i     (st_addr),
    .pix_i      (st_pix),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_pix_o    (m_axis_tdata),
    .m_inside_o (m_axis_tuser)
  );

endmodule

>>> rtl/core/irn_cfg.sv
// ----------------------------------------------------------------------------
// irn_cfg: configuration registers
// APB register file for the rotation coefficients and image size, with the
// image size limited to the range the frame store supports.
// ----------------------------------------------------------------------------
module irn_cfg #(
  parameter int unsigned MAX_DIM = irn_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [irn_pkg::APB_AW-1:0]             paddr,
  input  logic [irn_pkg::APB_DW-1:0]             pwdata,
  output logic [irn_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready,
  output logic signed [irn_pkg::COEF_W-1:0]      rot_cos_o,
  output logic signed [irn_pkg::COEF_W-1:0]      rot_sin_o,
  output logic [DIM_W-1:0]                       dim_w_o,
  output logic [DIM_W-1:0]                       dim_h_o
);

  localparam int unsigned CMPW = (DIM_W > irn_pkg::DIM_REG_W) ? DIM_W : irn_pkg::DIM_REG_W;

  logic signed [irn_pkg::COEF_W-1:0] cos_q, sin_q;
  logic [irn_pkg::DIM_REG_W-1:0]     width_q, height_q;
  logic                              wr_en;
  irn_pkg::irn_reg_e                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = irn_pkg::irn_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= irn_pkg::COS_RST;
      sin_q    <= irn_pkg::SIN_RST;
      width_q  <= irn_pkg::WIDTH_RST;
      height_q <= irn_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        irn_pkg::REG_COS:    cos_q    <= pwdata[irn_pkg::COEF_W-1:0];
        irn_pkg::REG_SIN:    sin_q    <= pwdata[irn_pkg::COEF_W-1:0];
        irn_pkg::REG_WIDTH:  width_q  <= pwdata[irn_pkg::DIM_REG_W-1:0];
        irn_pkg::REG_HEIGHT: height_q <= pwdata[irn_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      irn_pkg::REG_COS:    prdata = irn_pkg::APB_DW'(unsigned'(cos_q));
      irn_pkg::REG_SIN:    prdata = irn_pkg::APB_DW'(unsigned'(sin_q));
      irn_pkg::REG_WIDTH:  prdata = irn_pkg::APB_DW'(width_q);
      irn_pkg::REG_HEIGHT: prdata = irn_pkg::APB_DW'(height_q);
      default:             prdata = '0;
    endcase
  end

  // Size registers are limited to 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [irn_pkg::DIM_REG_W-1:0] v);
    logic [CMPW-1:0] ve;
    ve = CMPW'(v);
    if (ve == '0) begin
      clamp_dim = DIM_W'(1);
    end else if (ve > CMPW'(MAX_DIM)) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = DIM_W'(ve);
    end
  endfunction

  assign rot_cos_o = cos_q;
  assign rot_sin_o = sin_q;
  assign dim_w_o   = clamp_dim(width_q);
  assign dim_h_o   = clamp_dim(height_q);

endmodule

>>> rtl/core/irn_map.sv
// ----------------------------------------------------------------------------
// irn_map: coordinate mapping pipeline
// Four registered stages: centering, products, sums, rounding and bounds.
// Writes ride along unchanged so store accesses keep request order.
// ----------------------------------------------------------------------------
module irn_map #(
  parameter int unsigned MAX_DIM = irn_pkg::MAX_DIM_DEF,
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1),
  localparam int unsigned AW     = $clog2(MAX_DIM)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  input  irn_pkg::irn_cmd_e                 cmd_i,
  input  logic [irn_pkg::COORD_W-1:0]       x_i,
  input  logic [irn_pkg::COORD_W-1:0]       y_i,
  input  logic [irn_pkg::PIX_W-1:0]         pix_i,
  input  logic signed [irn_pkg::COEF_W-1:0] rot_cos_i,
  input  logic signed [irn_pkg::COEF_W-1:0] rot_sin_i,
  input  logic [DIM_W-1:0]                  dim_w_i,
  input  logic [DIM_W-1:0]                  dim_h_i,
  input  logic                              st_ready_i,
  output logic                              st_valid_o,
  output irn_pkg::irn_op_t                  st_op_o,
  output logic [2*AW-1:0]                   st_addr_o,
  output logic [irn_pkg::PIX_W-1:0]         st_pix_o
);

  localparam int unsigned FB   = irn_pkg::FRAC_BITS;
  localparam int unsigned CW   = (DIM_W > irn_pkg::COORD_W) ? DIM_W : irn_pkg::COORD_W;
  localparam int unsigned XM_W = CW + 1;
  localparam int unsigned PW   = XM_W + irn_pkg::COEF_W;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned QW   = SW - FB + 1;

  // Stage valids and load enables; a stage loads when empty or draining.
  logic v1_q, v2_q, v3_q, v4_q;
  logic ld1, ld2, ld3, ld4;

  assign ld4       = !v4_q || st_ready_i;
  assign ld3       = !v3_q || ld4;
  assign ld2       = !v2_q || ld3;
  assign ld1       = !v1_q || ld2;
  assign s_ready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= s_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
    end
  end

  // Centering.
  logic [CW-1:0]            xe, ye, wc, hc, hwc, hhc;
  logic signed [XM_W-1:0]   xm_d, ym_d;
  logic                     dest_ok_d, wr_ok_d;

  assign xe  = CW'(x_i);
  assign ye  = CW'(y_i);
  assign wc  = CW'(dim_w_i);
  assign hc  = CW'(dim_h_i);
  assign hwc = wc >> 1;
  assign hhc = hc >> 1;

  assign xm_d      = $signed({1'b0, xe}) - $signed({1'b0, hwc});
  assign ym_d      = $signed({1'b0, ye}) - $signed({1'b0, hhc});
  assign dest_ok_d = (xe < wc) && (ye < hc);
  assign wr_ok_d   = (xe < CW'(MAX_DIM)) && (ye < CW'(MAX_DIM));

  irn_pkg::irn_cmd_e        cmd1_q, cmd2_q, cmd3_q;
  logic                     dest1_q, dest2_q, dest3_q;
  logic                     wrok1_q, wrok2_q, wrok3_q;
  logic signed [XM_W-1:0]   xm1_q, ym1_q;
  logic [irn_pkg::PIX_W-1:0] pix1_q, pix2_q, pix3_q;
  logic [2*AW-1:0]          wa1_q, wa2_q, wa3_q;
  logic signed [PW-1:0]     pxc2_q, pys2_q, pxs2_q, pyc2_q;
  logic signed [SW-1:0]     u3_q, v3s_q;

  // Fixed-point image center offsets.
  logic signed [SW-1:0]     hw_off, hh_off;
  assign hw_off = $signed({{(SW - CW - FB){1'b0}}, hwc, {FB{1'b0}}});
  assign hh_off = $signed({{(SW - CW - FB){1'b0}}, hhc, {FB{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      cmd1_q  <= cmd_i;
      dest1_q <= dest_ok_d;
      wrok1_q <= wr_ok_d;
      xm1_q   <= xm_d;
      ym1_q   <= ym_d;
      pix1_q  <= pix_i;
      wa1_q   <= {ye[AW-1:0], xe[AW-1:0]};
    end
    if (ld2) begin
      cmd2_q  <= cmd1_q;
      dest2_q <= dest1_q;
      wrok2_q <= wrok1_q;
      pix2_q  <= pix1_q;
      wa2_q   <= wa1_q;
      pxc2_q  <= PW'(xm1_q) * PW'(rot_cos_i);
      pys2_q  <= PW'(ym1_q) * PW'(rot_sin_i);
      pxs2_q  <= PW'(xm1_q) * PW'(rot_sin_i);
      pyc2_q  <= PW'(ym1_q) * PW'(rot_cos_i);
    end
    if (ld3) begin
      cmd3_q  <= cmd2_q;
      dest3_q <= dest2_q;
      wrok3_q <= wrok2_q;
      pix3_q  <= pix2_q;
      wa3_q   <= wa2_q;
      u3_q    <= SW'(pxc2_q) - SW'(pys2_q) + hw_off;
      v3s_q   <= SW'(pxs2_q) + SW'(pyc2_q) + hh_off;
    end
  end

  // Round to nearest, halves away from zero.
  function automatic logic signed [QW-1:0] round_q(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] mag_r;
    logic [QW-1:0] q;
    mag     = v[SW-1] ? SW'(-v) : SW'(v);
    mag_r   = mag + SW'(1 << (FB - 1));
    q       = QW'(mag_r[SW-1:FB]);
    round_q = v[SW-1] ? $signed(-q) : $signed(q);
  endfunction

  logic signed [QW-1:0] xo, yo;
  logic                 in_x, in_y, is_read;
  irn_pkg::irn_op_t     op_d;

  assign xo      = round_q(u3_q);
  assign yo      = round_q(v3s_q);
  assign in_x    = !xo[QW-1] && (xo[QW-2:0] < (QW - 1)'(dim_w_i));
  assign in_y    = !yo[QW-1] && (yo[QW-2:0] < (QW - 1)'(dim_h_i));
  assign is_read = (cmd3_q == irn_pkg::CMD_READ);

  always_comb begin
    op_d.wr = !is_read && wrok3_q;
    op_d.rd = is_read && dest3_q && in_x && in_y;
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      st_op_o   <= op_d;
      st_addr_o <= is_read ? {yo[AW-1:0], xo[AW-1:0]} : wa3_q;
      st_pix_o  <= pix3_q;
    end
  end

  assign st_valid_o = v4_q;

endmodule

>>> rtl/core/irn_store.sv
// ----------------------------------------------------------------------------
// irn_store: frame store and result register
// Single-port pixel memory, one write or one read per request, with the
// read data register acting as the output stage.
// ----------------------------------------------------------------------------
module irn_store #(
  parameter int unsigned MAX_DIM = irn_pkg::MAX_DIM_DEF,
  localparam int unsigned AW     = $clog2(MAX_DIM),
  localparam int unsigned DEPTH  = 2 ** (2 * AW)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  irn_pkg::irn_op_t          op_i,
  input  logic [2*AW-1:0]           addr_i,
  input  logic [irn_pkg::PIX_W-1:0] pix_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [irn_pkg::PIX_W-1:0] m_pix_o,
  output logic                      m_inside_o
);

  logic [irn_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [irn_pkg::PIX_W-1:0] rdata_q;
  logic                      out_v_q, inside_q;
  logic                      ld;

  assign ld      = !out_v_q || m_ready_i;
  assign ready_o = ld;

  always_ff @(posedge clk_i) begin
    if (ld && valid_i && op_i.wr) mem_q[addr_i] <= pix_i;
    if (ld && valid_i && op_i.rd) rdata_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      inside_q <= 1'b0;
    end else if (ld) begin
      out_v_q  <= valid_i;
      inside_q <= valid_i && op_i.rd;
    end
  end

  assign m_valid_o  = out_v_q;
  assign m_inside_o = inside_q;
  assign m_pix_o    = inside_q ? rdata_q : '0;

endmodule

>>> rtl/core/irn_checker.sv
// ----------------------------------------------------------------------------
// irn_checker: port-level checks for the image rotator
// Tracks requests in flight and checks result stream behavior.
// ----------------------------------------------------------------------------
module irn_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [irn_pkg::PIX_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser
);

  // Four mapping stages plus the output register.
  localparam logic [2:0] MAX_IN_FLIGHT = 3'd5;

  logic [2:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != 3'd0)
    else $error("result presented with no request in flight");

  a_bounded_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_IN_FLIGHT)
    else $error("more requests in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while the output stage is empty");

  a_outside_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero pixel on a result without the inside flag");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for image_rotate_nearest
// Drives write and read requests over the request stream, programs the
// rotation and image size over the configuration port between phases, and
// compares every result against an in-bench model of the inverse mapping.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = irn_pkg::MAX_DIM_DEF;
  localparam longint HALF_LSB = longint'(1) <<< (irn_pkg::FRAC_BITS - 1);
  // Cycles to let the four-stage pipeline settle before a register write
  // and before the final verdict.
  localparam int SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int PHASE_COUNT = 14;
  localparam int PHASE_ITEMS = 125;

  // One request as the bench sees it, before packing onto the stream.
  typedef struct packed {
    irn_pkg::irn_cmd_e           cmd;
    logic [irn_pkg::COORD_W-1:0] x;
    logic [irn_pkg::COORD_W-1:0] y;
    logic [irn_pkg::PIX_W-1:0]   pix;
  } pix_req_t;

  // One result: the returned pixel and the inside flag.
  typedef struct packed {
    logic [irn_pkg::PIX_W-1:0] pixel;
    logic                      inside_flag;
  } rot_result_t;

  // Where a destination pixel lands in the source image.
  typedef struct packed {
    logic                          hit;
    logic [2*irn_pkg::COORD_W-1:0] addr;
  } src_map_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [irn_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [irn_pkg::PIX_W-1:0]      m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [irn_pkg::APB_AW-1:0]     paddr         = '0;
  logic [irn_pkg::APB_DW-1:0]     pwdata        = '0;
  logic [irn_pkg::APB_DW-1:0]     prdata;
  logic                           pready;

  // Shadow copy of the configuration registers. They only change while the
  // block is idle, so the request generator and the result model can share
  // them.
  logic signed [irn_pkg::COEF_W-1:0] cfg_cos    = irn_pkg::COS_RST;
  logic signed [irn_pkg::COEF_W-1:0] cfg_sin    = irn_pkg::SIN_RST;
  logic [irn_pkg::DIM_REG_W-1:0]     cfg_width  = irn_pkg::WIDTH_RST;
  logic [irn_pkg::DIM_REG_W-1:0]     cfg_height = irn_pkg::HEIGHT_RST;

  pix_req_t    req_q[$];          // requests waiting to be driven
  rot_result_t rotated_q[$];      // results the block still owes us
  logic [irn_pkg::PIX_W-1:0] frame_copy [DIM*DIM];
  bit          loaded [DIM*DIM];  // store entries the generator has written
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          err_cnt        = 0;
  int          queued_cnt     = 0;
  int unsigned cycle_cnt      = 0;

  image_rotate_nearest u_top (.*);

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reset is held at the start and never again.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit, far above the slowest run under the idling settings the bench uses.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Model of the inverse mapping
  // --------------------------------------------------------------------------

  // The size registers are saturated into 1..DIM before use.
  function automatic int clamp_dim(logic [irn_pkg::DIM_REG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return int'(d);
  endfunction

  // Divide by 2^FRAC_BITS, rounding to nearest with halves away from zero.
  function automatic longint round_frac(longint q);
    if (q >= 0) return (q + HALF_LSB) >>> irn_pkg::FRAC_BITS;
    return -((-q + HALF_LSB) >>> irn_pkg::FRAC_BITS);
  endfunction

  // Map a destination pixel back to the source image. A miss covers both a
  // destination outside the image and a source point that falls outside it.
  function automatic src_map_t map_to_source(logic [irn_pkg::COORD_W-1:0] dx,
                                             logic [irn_pkg::COORD_W-1:0] dy);
    src_map_t r;
    longint w, h, c, s, hw, hh, xm, ym, xo, yo;
    r  = '0;
    w  = clamp_dim(cfg_width);
    h  = clamp_dim(cfg_height);
    c  = longint'(cfg_cos);
    s  = longint'(cfg_sin);
    hw = w / 2;
    hh = h / 2;
    if (longint'(dx) >= w || longint'(dy) >= h) return r;
    xm = longint'(dx) - hw;
    ym = longint'(dy) - hh;
    xo = round_frac(xm * c - ym * s + (hw <<< irn_pkg::FRAC_BITS));
    yo = round_frac(xm * s + ym * c + (hh <<< irn_pkg::FRAC_BITS));
    if (xo >= 0 && xo < w && yo >= 0 && yo < h) begin
      r.hit  = 1'b1;
      r.addr = (2*irn_pkg::COORD_W)'(yo * DIM + xo);
    end
    return r;
  endfunction

  // Apply one accepted request to the store copy and return what the block
  // must answer. Writes always answer pixel 0 with the flag clear.
  function automatic rot_result_t rotate_request(pix_req_t r);
    rot_result_t res;
    src_map_t    m;
    res = '0;
    if (r.cmd == irn_pkg::CMD_WRITE) begin
      frame_copy[int'(r.y) * DIM + int'(r.x)] = r.pix;
    end else begin
      m = map_to_source(r.x, r.y);
      if (m.hit) begin
        res.pixel       = frame_copy[m.addr];
        res.inside_flag = 1'b1;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // A request is taken by the block at an edge where tvalid and tready are
  // both high; the expected result is worked out right there. A new request
  // is presented whenever the stream slot is free, unless the sender idles.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    pix_req_t taken;
    pix_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.cmd = irn_pkg::irn_cmd_e'(s_axis_tuser);
        taken.x   = s_axis_tdata[5:0];
        taken.y   = s_axis_tdata[11:6];
        taken.pix = s_axis_tdata[43:12];
        rotated_q = {rotated_q, rotate_request(taken)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, nxt.pix, nxt.y, nxt.x};
          s_axis_tuser  <= nxt.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  // Every result taken from the block is matched against the oldest
  // expectation, field by field. tready is redrawn every cycle so that
  // stalls land on every stage of the pipeline.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    rot_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: result with nothing pending: expected none, actual pixel %h inside %b",
                   $time, m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          want = rotated_q.pop_front();
          if (m_axis_tdata !== want.pixel) begin
            $display("%0t: pixel mismatch: expected %h, actual %h",
                     $time, want.pixel, m_axis_tdata);
            err_cnt++;
          end
          if (m_axis_tuser !== want.inside_flag) begin
            $display("%0t: inside flag mismatch: expected %b, actual %b",
                     $time, want.inside_flag, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Request generation and configuration
  // --------------------------------------------------------------------------

  function automatic void queue_write(int x, int y, logic [irn_pkg::PIX_W-1:0] pix);
    pix_req_t r;
    r.cmd = irn_pkg::CMD_WRITE;
    r.x   = irn_pkg::COORD_W'(x);
    r.y   = irn_pkg::COORD_W'(y);
    r.pix = pix;
    req_q = {req_q, r};
    loaded[y * DIM + x] = 1'b1;
    queued_cnt++;
  endfunction

  // A read whose source pixel has never been stored would return undefined
  // data, so such a read is preceded by a write of that source pixel.
  function automatic void queue_read(int x, int y);
    src_map_t m;
    pix_req_t r;
    m = map_to_source(irn_pkg::COORD_W'(x), irn_pkg::COORD_W'(y));
    if (m.hit && !loaded[m.addr]) queue_write(m.addr % DIM, m.addr / DIM, $urandom);
    r.cmd = irn_pkg::CMD_READ;
    r.x   = irn_pkg::COORD_W'(x);
    r.y   = irn_pkg::COORD_W'(y);
    r.pix = $urandom;
    req_q = {req_q, r};
    queued_cnt++;
  endfunction

  // Wait until every request has gone in and every result has come back,
  // then give the pipeline time to empty.
  task automatic wait_idle();
    while (req_q.size() != 0 || s_axis_tvalid || rotated_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register is written at the edge
  // that closes the access cycle.
  task automatic reg_write(irn_pkg::irn_reg_e idx, logic [irn_pkg::APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      irn_pkg::REG_COS:    cfg_cos    = val[irn_pkg::COEF_W-1:0];
      irn_pkg::REG_SIN:    cfg_sin    = val[irn_pkg::COEF_W-1:0];
      irn_pkg::REG_WIDTH:  cfg_width  = val[irn_pkg::DIM_REG_W-1:0];
      irn_pkg::REG_HEIGHT: cfg_height = val[irn_pkg::DIM_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_rotation(int cos_v, int sin_v, int w_v, int h_v);
    wait_idle();
    reg_write(irn_pkg::REG_COS,    irn_pkg::APB_DW'(irn_pkg::COEF_W'(cos_v)));
    reg_write(irn_pkg::REG_SIN,    irn_pkg::APB_DW'(irn_pkg::COEF_W'(sin_v)));
    reg_write(irn_pkg::REG_WIDTH,  irn_pkg::APB_DW'(irn_pkg::DIM_REG_W'(w_v)));
    reg_write(irn_pkg::REG_HEIGHT, irn_pkg::APB_DW'(irn_pkg::DIM_REG_W'(h_v)));
  endtask

  // Random traffic under the current setting, at least n requests counting the
  // writes that reads pull in. Writes mostly land inside the active image so
  // that reads find stored pixels; some reads name destinations beyond it.
  task automatic random_traffic(int n);
    int wc, hc, stop_at;
    wc      = clamp_dim(cfg_width);
    hc      = clamp_dim(cfg_height);
    stop_at = queued_cnt + n;
    while (queued_cnt < stop_at) begin
      if ($urandom_range(99) < 35) begin
        if ($urandom_range(99) < 85)
          queue_write($urandom_range(wc - 1), $urandom_range(hc - 1), $urandom);
        else
          queue_write($urandom_range(DIM - 1), $urandom_range(DIM - 1), $urandom);
      end else begin
        if ($urandom_range(99) < 80)
          queue_read($urandom_range(wc - 1), $urandom_range(hc - 1));
        else
          queue_read($urandom_range(DIM - 1), $urandom_range(DIM - 1));
      end
    end
  endtask

  initial begin : stimulus
    int c_v, s_v, w_v, h_v;
    while (!rst_ni) @(posedge clk_i);

    // Identity setting: extreme-valued corner pixels and the center, read straight back.
    set_rotation(16384, 0, 64, 64);
    queue_write(0, 0, '1);
    queue_write(DIM - 1, DIM - 1, '0);
    queue_write(DIM - 1, 0, 32'hA5A5_A5A5);
    queue_write(0, DIM - 1, 32'h5A5A_5A5A);
    queue_read(0, 0);
    queue_read(DIM - 1, DIM - 1);
    queue_read(DIM - 1, 0);
    queue_read(0, DIM - 1);
    queue_read(32, 32);

    // Quarter turn: the top-left corner maps outside the source image.
    set_rotation(0, 16384, 64, 64);
    queue_read(0, 0);
    queue_read(0, DIM - 1);

    // Half-unit coefficients put the source exactly halfway between pixels on both axes.
    set_rotation(8192, -8192, 64, 64);
    queue_read(33, 32);
    queue_read(31, 32);
    queue_read(32, 33);
    queue_read(32, 31);

    // One column wide: minus one half must round to -1, which lies outside.
    set_rotation(16384, 8192, 1, 64);
    queue_read(0, 33);
    queue_read(0, 31);

    // Size registers out of range are saturated; a destination beyond the
    // image answers with the flag clear.
    set_rotation(16384, 0, 0, 127);
    queue_read(0, 0);
    queue_read(1, 5);

    // Traffic phases, each under its own setting, cycling through four idling patterns.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      c_v = int'($urandom_range(32768)) - 16384;
      s_v = int'($urandom_range(32768)) - 16384;
      w_v = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
      h_v = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
      case (ph)
        0: set_rotation(16384, 0, 64, 64);
        1: set_rotation(0, 16384, 64, 64);
        2: set_rotation(-16384, 0, 64, 64);
        3: set_rotation(0, -16384, 37, 50);
        4: set_rotation(11585, 11585, 64, 64);
        5: set_rotation(8192, 0, 33, 17);
        6: set_rotation(-16384, -16384, 1, 1);
        // Coefficients at the very ends of the 16-bit range.
        7: set_rotation(-32768, 32767, 64, 64);
        8: set_rotation($urandom_range(65535), $urandom_range(65535), 0, 127);
        default: set_rotation(c_v, s_v, w_v, h_v);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      random_traffic(PHASE_ITEMS);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> image_rotate_nearest.f
rtl/core/irn_pkg.sv
rtl/core/irn_cfg.sv
rtl/core/irn_map.sv
rtl/core/irn_store.sv
rtl/core/image_rotate_nearest.sv
rtl/core/irn_checker.sv
sim/testbench.sv
